### design/u8lex_pkg.sv
package u8lex_pkg;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_MATCH = 8'h80;

  localparam logic [31:0] START_MIN = 32'h0000_00C0;
  localparam logic [31:0] PART_MIN  = 32'h0000_0080;

  localparam logic [2:0] COUNT_MAX = 3'd6;

  typedef struct packed {
    logic [31:0] code_point;
    logic [31:0] start_offset;
    logic [31:0] line_number;
    logic [2:0]  byte_count;
    logic        is_whitespace;
    logic        is_comment;
    logic        is_digit;
    logic        is_hex;
    logic        ident_start;
    logic        ident_part;
    logic        is_last;
  } res_t;

  typedef struct packed {
    logic pending;
    logic in_comment;
  } status_t;

  // Offset removed from the shifted sum for a sequence of n bytes.
  function automatic logic [31:0] len_offset(input logic [2:0] n);
    logic [31:0] off;
    case (n)
      3'd2:    off = 32'h0000_3080;
      3'd3:    off = 32'h000E_2080;
      3'd4:    off = 32'h03C8_2080;
      3'd5:    off = 32'hFA08_2080;
      3'd6:    off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

endpackage

### design/u8lex_decode.sv
module u8lex_decode #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          first_line,
  input  logic                 step,
  input  logic                 kind,
  input  logic [7:0]           byte_in,
  output logic                 emit,
  output u8lex_pkg::res_t      res,
  output u8lex_pkg::status_t   status
);
  import u8lex_pkg::*;

  logic [31:0]            acc_r, acc_nxt;
  logic [2:0]             pcount_r, pcount_nxt;
  logic [7:0]             lead_r, lead_nxt;
  logic [OFFSET_BITS-1:0] poff_r, poff_nxt;
  logic [OFFSET_BITS-1:0] boff_r, boff_nxt;
  logic [31:0]            line_r, line_nxt;
  logic                   incom_r, incom_nxt;

  logic        pending;
  logic        is_cont;
  logic [2:0]  n;
  logic [31:0] cp;
  logic        letter;
  logic        digit;
  logic        com;
  logic        ws;
  logic        incom_after;

  assign pending = (pcount_r != 3'd0);
  assign is_cont = ((byte_in & CONT_MASK) == CONT_MATCH);
  assign n       = pending ? pcount_r : 3'd1;
  assign cp      = acc_r - len_offset(n);

  always_comb begin
    letter = ((cp >= {24'd0, CH_LO_A}) && (cp <= {24'd0, CH_LO_Z})) ||
             ((cp >= {24'd0, CH_UP_A}) && (cp <= {24'd0, CH_UP_Z}));
    digit  = (lead_r >= CH_ZERO) && (lead_r <= CH_NINE);
    if (incom_r) begin
      com         = 1'b1;
      ws          = 1'b0;
      incom_after = (lead_r != CH_LF);
    end else if (lead_r == CH_HASH) begin
      com         = 1'b1;
      ws          = 1'b0;
      incom_after = 1'b1;
    end else begin
      com         = 1'b0;
      ws          = (lead_r == CH_SPACE) || (lead_r == CH_TAB) ||
                    (lead_r == CH_CR) || (lead_r == CH_LF);
      incom_after = 1'b0;
    end
  end

  always_comb begin
    res.code_point    = cp;
    res.start_offset  = 32'(poff_r);
    res.line_number   = line_r;
    res.byte_count    = n;
    res.is_whitespace = ws;
    res.is_comment    = com;
    res.is_digit      = digit;
    res.is_hex        = digit || ((lead_r >= CH_LO_A) && (lead_r <= CH_LO_F)) ||
                        ((lead_r >= CH_UP_A) && (lead_r <= CH_UP_F));
    res.ident_start   = letter || (cp == {24'd0, CH_USCORE}) || (cp >= START_MIN);
    res.ident_part    = letter || (cp == {24'd0, CH_USCORE}) ||
                        ((cp >= {24'd0, CH_ZERO}) && (cp <= {24'd0, CH_NINE})) ||
                        (cp >= PART_MIN);
    res.is_last       = (kind == KIND_END);
  end

  assign status.pending    = pending;
  assign status.in_comment = incom_r;

  always_comb begin
    acc_nxt    = acc_r;
    pcount_nxt = pcount_r;
    lead_nxt   = lead_r;
    poff_nxt   = poff_r;
    boff_nxt   = boff_r;
    line_nxt   = line_r;
    incom_nxt  = incom_r;
    emit       = 1'b0;
    if (kind == KIND_END) begin
      emit       = pending;
      acc_nxt    = 32'd0;
      pcount_nxt = 3'd0;
      lead_nxt   = 8'd0;
      poff_nxt   = '0;
      boff_nxt   = '0;
      line_nxt   = {16'd0, first_line};
      incom_nxt  = 1'b0;
    end else begin
      boff_nxt = boff_r + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
      if (pending && is_cont) begin
        acc_nxt = {acc_r[25:0], 6'd0} + {24'd0, byte_in};
        if (pcount_r < COUNT_MAX) begin
          pcount_nxt = pcount_r + 3'd1;
        end
      end else begin
        emit = pending;
        if (pending) begin
          incom_nxt = incom_after;
          if (lead_r == CH_LF) begin
            line_nxt = line_r + 32'd1;
          end
        end
        acc_nxt    = {24'd0, byte_in};
        pcount_nxt = 3'd1;
        lead_nxt   = byte_in;
        poff_nxt   = boff_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= 32'd0;
      pcount_r <= 3'd0;
      lead_r   <= 8'd0;
      poff_r   <= '0;
      boff_r   <= '0;
      line_r   <= 32'd1;
      incom_r  <= 1'b0;
    end else if (step) begin
      acc_r    <= acc_nxt;
      pcount_r <= pcount_nxt;
      lead_r   <= lead_nxt;
      poff_r   <= poff_nxt;
      boff_r   <= boff_nxt;
      line_r   <= line_nxt;
      incom_r  <= incom_nxt;
    end
  end

endmodule

### design/utf8_lexer_char_scanner.sv
// UTF-8 character scanner for a lexer front end.
// Input channel: one transfer per source byte (in_kind = 0) or an end-of-source
// marker (in_kind = 1) that flushes the pending character and restarts offset,
// line and comment tracking. in_byte_req is ignored for the end marker.
// Result channel: one transfer per completed character with its code point,
// start offset, line, byte count and lexer classes; out_is_last marks a result
// produced by the end marker.
// A character completes when the next non-continuation byte or the end marker
// arrives. The decode logic sits between the input register and the result
// register, so a result is loaded when the item that completes its character
// advances out of the input register; it transfers out from there.
// Throughput is one input byte per cycle unless out_stall holds a result; the
// decode step is a single shift-add plus a subtract and range compares.
// cfg_wr_en/cfg_wr_data set the first line number, used at the next end of
// source. Synchronous reset clears both pipeline registers, drops all
// pending state and restores the first line to 1. in_stall is high in reset.
// When out_stall holds a result, the input register still drains items that
// produce no result; an item that would produce one waits, and in_stall rises
// once the input register is also occupied.
module utf8_lexer_char_scanner #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_byte_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_code_point,
  output logic [31:0] out_start_offset,
  output logic [31:0] out_line_number,
  output logic [2:0]  out_byte_count,
  output logic        out_is_whitespace,
  output logic        out_is_comment,
  output logic        out_is_digit,
  output logic        out_is_hex,
  output logic        out_ident_start,
  output logic        out_ident_part,
  output logic        out_is_last
);
  import u8lex_pkg::*;

  logic [15:0] first_line_r;
  logic        a_valid_r, a_valid_nxt;
  logic        a_kind_r;
  logic [7:0]  a_byte_r;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_r;
  res_t        dec_res;
  status_t     dec_status;
  logic        dec_emit;
  logic        in_take;
  logic        advance;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = a_valid_r && (out_free || !dec_emit);
  assign in_stall = !rst_n || (a_valid_r && !advance);
  assign in_take  = in_valid && !in_stall;

  u8lex_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .first_line (first_line_r),
    .step       (advance),
    .kind       (a_kind_r),
    .byte_in    (a_byte_r),
    .emit       (dec_emit),
    .res        (dec_res),
    .status     (dec_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_line_r <= 16'd1;
    end else if (cfg_wr_en) begin
      first_line_r <= cfg_wr_data;
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_take) begin
      a_valid_nxt = 1'b1;
    end else if (advance) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && dec_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_kind_r <= in_kind;
      a_byte_r <= in_byte_req;
    end
    if (advance && dec_emit) begin
      out_r <= dec_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_point    = out_r.code_point;
  assign out_start_offset  = out_r.start_offset;
  assign out_line_number   = out_r.line_number;
  assign out_byte_count    = out_r.byte_count;
  assign out_is_whitespace = out_r.is_whitespace;
  assign out_is_comment    = out_r.is_comment;
  assign out_is_digit      = out_r.is_digit;
  assign out_is_hex        = out_r.is_hex;
  assign out_ident_start   = out_r.ident_start;
  assign out_ident_part    = out_r.ident_part;
  assign out_is_last       = out_r.is_last;

  // The end marker always leaves nothing pending and the comment flag clear.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (a_kind_r == KIND_END) |=> !dec_status.pending && !dec_status.in_comment)
    else $error("end of source did not restart the decoder");

  // A taken result with nothing new behind it empties the result register.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !(advance && dec_emit) |=> !out_valid_r)
    else $error("result register did not drain");

  // With an empty result register the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while the result register was free");

  // A result only ever comes from a character that was pending.
  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    advance && dec_emit |=> out_valid_r && $past(dec_status.pending))
    else $error("result produced without a pending character");

endmodule
